// File: sv/cdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_pkg: shared types and constants of the centroid defuzzifier
// Holds accumulator widths, status codes, controller states and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cdf_pkg;

	// accumulator widths (fixed by the block definition)
	localparam int AREA_WIDTH    = 40;
	localparam int MOMENT_WIDTH  = 56;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS     = MOMENT_WIDTH;
	localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_ZERO_AREA = 2'd2;
	localparam logic [1:0] STATUS_ORDER     = 2'd3;

	// point count saturates at two
	localparam logic [1:0] COUNT_NONE = 2'd0;
	localparam logic [1:0] COUNT_ONE  = 2'd1;
	localparam logic [1:0] COUNT_MANY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} cdf_state_t;

	typedef struct packed {
		logic accept;    // input beat taken this cycle
		logic acc;       // add registered products into the sums
		logic div_load;  // load divider operands
		logic div_step;  // one restoring divide step
		logic out_load;  // capture result into output register
		logic clear;     // drop all set state
	} cdf_cmd_t;

	typedef struct packed {
		logic last;      // beat just taken closes the set
		logic need_div;  // set ends in a regular quotient
	} cdf_stat_t;

endpackage
`default_nettype wire

// File: sv/cdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_ctrl: sequencer of the centroid defuzzifier
// Walks each beat through accept and accumulate, then on the closing beat
// through the check, the divide loop when a quotient is needed and the result handoff.
// ----------------------------------------------------------------------------
module cdf_ctrl
	import cdf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire cdf_stat_t stat,
	output cdf_cmd_t       cmd
);

	cdf_state_t               state_q, state_d;
	logic [DIV_CNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                     out_valid_q, out_valid_d;

	// state, step counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				cmd.div_load = 1'b1;
				cnt_d        = DIV_CNT_WIDTH'(DIV_STEPS - 1);
				state_d      = stat.need_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold the result beat until taken
	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: sv/cdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_datapath: arithmetic of the centroid defuzzifier
// Trapezoid area and moment products, area and moment sums, order check,
// restoring divider and result selection with saturation.
// ----------------------------------------------------------------------------
module cdf_datapath
	import cdf_pkg::*;
#(
	parameter int X_WIDTH             = 16,
	parameter int GRADE_FRACTION_BITS = 15
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cdf_cmd_t                     cmd,
	input  wire logic signed [X_WIDTH-1:0]    point_x,
	input  wire logic [GRADE_FRACTION_BITS:0] grade,
	input  wire logic                         point_valid,
	input  wire logic                         last_point,
	output cdf_stat_t                         stat,
	output logic signed [X_WIDTH-1:0]         centroid,
	output logic [1:0]                        status
);

	localparam int GW  = GRADE_FRACTION_BITS + 1;     // grade width
	localparam int AP  = X_WIDTH + GW + 1;            // area product width
	localparam int PW  = AP + X_WIDTH + 2;            // moment product width
	localparam int REM = AREA_WIDTH + 2;              // divider remainder width

	// set state
	logic signed [X_WIDTH-1:0] prev_x_q;
	logic [GW-1:0]             prev_g_q;
	logic [1:0]                count_q;
	logic                      err_q;
	logic [AREA_WIDTH-1:0]     area_sum_q;
	logic [MOMENT_WIDTH-1:0]   moment_sum_q;

	// first stage: area product and position sum
	logic [AP-1:0]             area_s1;
	logic signed [X_WIDTH:0]   xs_s1;
	logic                      acc_s1;
	logic                      last_s1;

	// divider
	logic [REM-2:0]            rem_q;
	logic [MOMENT_WIDTH-1:0]   quo_q;
	logic [AREA_WIDTH:0]       dvs_q;
	logic                      neg_q;

	// result register
	logic signed [X_WIDTH-1:0] centroid_q;
	logic [1:0]                status_q;

	// step width and position sum of the incoming point
	logic signed [X_WIDTH:0]   h;
	logic signed [X_WIDTH:0]   xs;
	logic                      h_pos;
	logic [GW:0]               gsum;
	logic [AP-1:0]             aprod;
	logic                      has_prev;

	assign h        = $signed({point_x[X_WIDTH-1], point_x})
		- $signed({prev_x_q[X_WIDTH-1], prev_x_q});
	assign xs       = $signed({point_x[X_WIDTH-1], point_x})
		+ $signed({prev_x_q[X_WIDTH-1], prev_x_q});
	assign h_pos    = !h[X_WIDTH] && (h != '0);
	assign gsum     = {1'b0, prev_g_q} + {1'b0, grade};
	assign aprod    = AP'(h[X_WIDTH-1:0]) * AP'(gsum);
	assign has_prev = (count_q != COUNT_NONE);

	// moment product of the registered area
	logic signed [PW-1:0]               mprod;

	assign mprod     = $signed({1'b0, area_s1}) * xs_s1;

	// capture the products of the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			area_s1 <= aprod;
			xs_s1   <= xs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else if (cmd.accept) begin
			acc_s1  <= point_valid && has_prev && h_pos && !err_q;
			last_s1 <= last_point;
		end
	end

	// update set state: previous point, count, order flag, sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q     <= '0;
			prev_g_q     <= '0;
			count_q      <= COUNT_NONE;
			err_q        <= 1'b0;
			area_sum_q   <= '0;
			moment_sum_q <= '0;
		end else if (cmd.clear) begin
			prev_x_q     <= '0;
			prev_g_q     <= '0;
			count_q      <= COUNT_NONE;
			err_q        <= 1'b0;
			area_sum_q   <= '0;
			moment_sum_q <= '0;
		end else begin
			if (cmd.accept && point_valid) begin
				prev_x_q <= point_x;
				prev_g_q <= grade;
				if (count_q != COUNT_MANY) begin
					count_q <= count_q + 1'b1;
				end
				if (has_prev && !h_pos) begin
					err_q <= 1'b1;
				end
			end
			if (cmd.acc && acc_s1) begin
				area_sum_q   <= area_sum_q + AREA_WIDTH'(area_s1);
				moment_sum_q <= moment_sum_q + MOMENT_WIDTH'(mprod);
			end
		end
	end

	// operand magnitudes for the divider
	logic [MOMENT_WIDTH-1:0] m_abs;
	logic [AREA_WIDTH-1:0]   a_abs;
	logic                    area_zero;

	assign m_abs     = moment_sum_q[MOMENT_WIDTH-1] ? (~moment_sum_q + 1'b1) : moment_sum_q;
	assign a_abs     = area_sum_q[AREA_WIDTH-1] ? (~area_sum_q + 1'b1) : area_sum_q;
	assign area_zero = (area_sum_q == '0);

	// one restoring step: shift in a dividend bit, subtract if it fits
	logic [REM-1:0] rem_sh;
	logic [REM-1:0] rem_diff;
	logic           fits;

	assign rem_sh   = {rem_q, quo_q[MOMENT_WIDTH-1]};
	assign fits     = (rem_sh >= {1'b0, dvs_q});
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= m_abs;
			dvs_q <= {a_abs, 1'b0};
			neg_q <= moment_sum_q[MOMENT_WIDTH-1] ^ area_sum_q[AREA_WIDTH-1];
		end else if (cmd.div_step) begin
			rem_q <= fits ? rem_diff[REM-2:0] : rem_sh[REM-2:0];
			quo_q <= {quo_q[MOMENT_WIDTH-2:0], fits};
		end
	end

	// saturate the signed quotient to the position range
	logic                      pos_ovf;
	logic                      neg_ovf;
	logic signed [X_WIDTH-1:0] quo_sat;
	logic signed [X_WIDTH-1:0] sel_centroid;
	logic [1:0]                sel_status;

	assign pos_ovf = |quo_q[MOMENT_WIDTH-1:X_WIDTH-1];
	assign neg_ovf = (|quo_q[MOMENT_WIDTH-1:X_WIDTH])
		|| (quo_q[X_WIDTH-1] && (|quo_q[X_WIDTH-2:0]));

	always_comb begin
		if (neg_q) begin
			quo_sat = neg_ovf ? {1'b1, {(X_WIDTH-1){1'b0}}}
				: (~quo_q[X_WIDTH-1:0] + 1'b1);
		end else begin
			quo_sat = pos_ovf ? {1'b0, {(X_WIDTH-1){1'b1}}} : quo_q[X_WIDTH-1:0];
		end
	end

	// pick the result of the set
	always_comb begin
		priority if (count_q == COUNT_NONE) begin
			sel_centroid = '0;
			sel_status   = STATUS_EMPTY;
		end else if (count_q == COUNT_ONE) begin
			sel_centroid = prev_x_q;
			sel_status   = STATUS_OK;
		end else if (err_q) begin
			sel_centroid = '0;
			sel_status   = STATUS_ORDER;
		end else if (area_zero) begin
			sel_centroid = '0;
			sel_status   = STATUS_ZERO_AREA;
		end else begin
			sel_centroid = quo_sat;
			sel_status   = STATUS_OK;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			centroid_q <= sel_centroid;
			status_q   <= sel_status;
		end
	end

	assign stat.last     = last_s1;
	assign stat.need_div = (count_q == COUNT_MANY) && !err_q && !area_zero;
	assign centroid      = centroid_q;
	assign status        = status_q;

endmodule
`default_nettype wire

// File: sv/centroid_defuzzifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centroid_defuzzifier_core: centroid of a discrete fuzzy set
// Trapezoidal-rule area and moment sums over ascending points; the closing
// beat yields moment / (2 * area), truncated toward zero and saturated.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | point_x, grade, point_valid, last_point
//  out     | out_valid / out_ready| centroid, status
//
//  Each input beat passes through accept with the area multiply, then the
//  moment multiply and accumulate; in_ready is high only in the accept step.
//  A closing beat then adds the check, the divider loop when a quotient is
//  needed, and the load of the output register, held while it is full.
//  arst_n clears all set state and the result flag.
// ----------------------------------------------------------------------------
module centroid_defuzzifier_core
	import cdf_pkg::*;
#(
	parameter int X_WIDTH             = 16,
	parameter int GRADE_FRACTION_BITS = 15
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [X_WIDTH-1:0]    point_x,
	input  wire logic [GRADE_FRACTION_BITS:0] grade,
	input  wire logic                         point_valid,
	input  wire logic                         last_point,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [X_WIDTH-1:0]         centroid,
	output logic [1:0]                        status
);

	cdf_cmd_t  cmd;
	cdf_stat_t stat;

	// sequencer
	cdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic
	cdf_datapath #(
		.X_WIDTH             (X_WIDTH),
		.GRADE_FRACTION_BITS (GRADE_FRACTION_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.point_x     (point_x),
		.grade       (grade),
		.point_valid (point_valid),
		.last_point  (last_point),
		.stat        (stat),
		.centroid    (centroid),
		.status      (status)
	);

endmodule
`default_nettype wire
